// ===== hdl/tlbr_pkg.sv =====
package tlbr_pkg;

    localparam int TLB_ENTRIES_DEF      = 64;
    localparam int STACK_PAGES_DEF      = 18;
    localparam int PAGE_OFFSET_BITS_DEF = 12;

    localparam int ADDR_W      = 32;
    localparam int PAGES_W     = 20;
    localparam int CFG_INDEX_W = 3;
    localparam int SLOT_OUT_W  = 6;

    localparam logic [ADDR_W-1:0]     STACK_TOP_RESET = 32'h8000_0000;
    localparam logic [ADDR_W-1:0]     ENTRY_VALID_BIT = 32'h0000_0200;
    localparam logic [ADDR_W-1:0]     ENTRY_DIRTY_BIT = 32'h0000_0400;

    localparam logic [CFG_INDEX_W-1:0] REG_CODE_BASE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CODE_PAGES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_BASE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_PAGES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STACK_TOP  = 3'd4;

    typedef enum logic [1:0] {
        KIND_FAULT = 2'd0,
        KIND_CODE  = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_STACK = 2'd3
    } kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  code_base;
        logic [PAGES_W-1:0] code_pages;
        logic [ADDR_W-1:0]  data_base;
        logic [PAGES_W-1:0] data_pages;
        logic [ADDR_W-1:0]  stack_top;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic bounds;
        logic classify;
        logic commit;
    } cmd_t;

endpackage

// ===== hdl/tlbr_cfg.sv =====
module tlbr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tlbr_pkg::ADDR_W-1:0]      cfg_data,
    output tlbr_pkg::cfg_t                   cfg
);
    import tlbr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CODE_BASE:  cfg_next.code_base  = cfg_data;
                REG_CODE_PAGES: cfg_next.code_pages = cfg_data[PAGES_W-1:0];
                REG_DATA_BASE:  cfg_next.data_base  = cfg_data;
                REG_DATA_PAGES: cfg_next.data_pages = cfg_data[PAGES_W-1:0];
                REG_STACK_TOP:  cfg_next.stack_top  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_base  <= '0;
            cfg_reg.code_pages <= '0;
            cfg_reg.data_base  <= '0;
            cfg_reg.data_pages <= '0;
            cfg_reg.stack_top  <= STACK_TOP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/tlbr_ctrl.sv =====
module tlbr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output tlbr_pkg::cmd_t cmd
);
    import tlbr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_BOUNDS = 4'b0010,
        ST_CLASS  = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_BOUNDS;
            ST_BOUNDS: state_next = ST_CLASS;
            ST_CLASS:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cmd.load     = start && (state_reg == ST_IDLE);
    assign cmd.bounds   = (state_reg == ST_BOUNDS);
    assign cmd.classify = (state_reg == ST_CLASS);
    assign cmd.commit   = (state_reg == ST_COMMIT);

endmodule

// ===== hdl/tlbr_dp.sv =====
module tlbr_dp #(
    parameter int TLB_ENTRIES      = tlbr_pkg::TLB_ENTRIES_DEF,
    parameter int STACK_PAGES      = tlbr_pkg::STACK_PAGES_DEF,
    parameter int PAGE_OFFSET_BITS = tlbr_pkg::PAGE_OFFSET_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlbr_pkg::cmd_t                  cmd,
    input  tlbr_pkg::cfg_t                  cfg,
    input  logic [tlbr_pkg::ADDR_W-1:0]     fault_address,
    input  logic [tlbr_pkg::ADDR_W-1:0]     frame_address,
    output logic                            done,
    output logic [1:0]                      segment_kind,
    output logic [tlbr_pkg::SLOT_OUT_W-1:0] slot_index,
    output logic [tlbr_pkg::ADDR_W-1:0]     entry_high,
    output logic [tlbr_pkg::ADDR_W-1:0]     entry_low,
    output logic                            took_free_slot
);
    import tlbr_pkg::*;

    localparam int SLOT_W = $clog2(TLB_ENTRIES);
    localparam int FILL_W = $clog2(TLB_ENTRIES + 1);
    // segment ends are kept unwrapped, so one bit beyond the widest sum
    localparam int SUM_W  = ((PAGES_W + PAGE_OFFSET_BITS) > ADDR_W ?
                             (PAGES_W + PAGE_OFFSET_BITS) : ADDR_W) + 1;
    localparam logic [SUM_W-1:0]  STACK_SPAN = SUM_W'(STACK_PAGES) << PAGE_OFFSET_BITS;
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(TLB_ENTRIES);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(TLB_ENTRIES - 1);
    localparam logic [ADDR_W-1:0] PAGE_MASK  = ~((ADDR_W'(1) << PAGE_OFFSET_BITS) - ADDR_W'(1));

    // word held for the refill in flight
    logic [ADDR_W-1:0] page_reg;
    logic [ADDR_W-1:0] frame_reg;
    logic [SUM_W-1:0]  code_top_reg;
    logic [SUM_W-1:0]  data_top_reg;
    logic [ADDR_W-1:0] stack_base_reg;
    kind_t             kind_reg;
    kind_t             kind_next;

    // slots fill in ascending order and are never freed, so the lowest
    // free slot is always the fill count
    logic [FILL_W-1:0] fill_reg;
    logic [SLOT_W-1:0] ptr_reg;
    logic              done_reg;

    logic [1:0]            kind_out_reg;
    logic [SLOT_W-1:0]     slot_out_reg;
    logic [ADDR_W-1:0]     high_out_reg;
    logic [ADDR_W-1:0]     low_out_reg;
    logic                  free_out_reg;

    logic [SUM_W-1:0]  stack_top_ext;
    logic [SUM_W-1:0]  page_ext;
    logic [SUM_W-1:0]  stack_diff;
    logic              is_free;
    logic [SLOT_W-1:0] slot_sel;
    logic [ADDR_W-1:0] low_sel;
    logic              hit;

    assign stack_top_ext = SUM_W'(cfg.stack_top);
    assign stack_diff    = stack_top_ext - STACK_SPAN;
    assign page_ext      = SUM_W'(page_reg);

    always_comb
    begin
        kind_next = KIND_FAULT;
        if (page_reg >= cfg.code_base && page_ext < code_top_reg)
            kind_next = KIND_CODE;
        else if (page_reg >= cfg.data_base && page_ext < data_top_reg)
            kind_next = KIND_DATA;
        else if (page_reg >= stack_base_reg && page_reg < cfg.stack_top)
            kind_next = KIND_STACK;
    end

    assign hit      = (kind_reg != KIND_FAULT);
    assign is_free  = (fill_reg != FILL_FULL);
    assign slot_sel = is_free ? fill_reg[SLOT_W-1:0] : ptr_reg;
    assign low_sel  = (kind_reg == KIND_CODE) ?
                      ((frame_reg & ~ENTRY_DIRTY_BIT) | ENTRY_VALID_BIT) :
                      (frame_reg | ENTRY_DIRTY_BIT | ENTRY_VALID_BIT);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg  <= fault_address & PAGE_MASK;
            frame_reg <= frame_address;
        end
        if (cmd.bounds)
        begin
            code_top_reg   <= SUM_W'(cfg.code_base) +
                              (SUM_W'(cfg.code_pages) << PAGE_OFFSET_BITS);
            data_top_reg   <= SUM_W'(cfg.data_base) +
                              (SUM_W'(cfg.data_pages) << PAGE_OFFSET_BITS);
            stack_base_reg <= (stack_top_ext >= STACK_SPAN) ?
                              stack_diff[ADDR_W-1:0] : '0;
        end
        if (cmd.classify)
        begin
            kind_reg <= kind_next;
        end
        if (cmd.commit)
        begin
            kind_out_reg <= kind_reg;
            slot_out_reg <= hit ? slot_sel : '0;
            high_out_reg <= hit ? page_reg : '0;
            low_out_reg  <= hit ? low_sel : '0;
            free_out_reg <= hit && is_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ptr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.commit && hit)
            begin
                if (is_free)
                    fill_reg <= fill_reg + FILL_W'(1);
                else if (ptr_reg == SLOT_LAST)
                    ptr_reg <= '0;
                else
                    ptr_reg <= ptr_reg + SLOT_W'(1);
            end
        end
    end

    assign done           = done_reg;
    assign segment_kind   = kind_out_reg;
    assign slot_index     = SLOT_OUT_W'(slot_out_reg);
    assign entry_high     = high_out_reg;
    assign entry_low      = low_out_reg;
    assign took_free_slot = free_out_reg;

endmodule

// ===== hdl/tlb_refill_segment_round_robin.sv =====
// A refill steps through the bounds, classify and commit states after start; done is registered from commit.
// busy is high from the bounds state through commit; start is ignored while busy, so refills never overlap.
// The three steps are segment-end arithmetic, bound compares and slot choice.
// Results come with a one-cycle done strobe; the receiver cannot stall.
// Reset empties every slot, zeroes the victim pointer and loads the default bounds.
module tlb_refill_segment_round_robin #(
    parameter int TLB_ENTRIES      = tlbr_pkg::TLB_ENTRIES_DEF,
    parameter int STACK_PAGES      = tlbr_pkg::STACK_PAGES_DEF,
    parameter int PAGE_OFFSET_BITS = tlbr_pkg::PAGE_OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tlbr_pkg::ADDR_W-1:0]      fault_address,
    input  logic [tlbr_pkg::ADDR_W-1:0]      frame_address,
    output logic                             done,
    output logic [1:0]                       segment_kind,
    output logic [tlbr_pkg::SLOT_OUT_W-1:0]  slot_index,
    output logic [tlbr_pkg::ADDR_W-1:0]      entry_high,
    output logic [tlbr_pkg::ADDR_W-1:0]      entry_low,
    output logic                             took_free_slot,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tlbr_pkg::ADDR_W-1:0]      cfg_data
);
    import tlbr_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    tlbr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlbr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    tlbr_dp #(
        .TLB_ENTRIES      (TLB_ENTRIES),
        .STACK_PAGES      (STACK_PAGES),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .fault_address  (fault_address),
        .frame_address  (frame_address),
        .done           (done),
        .segment_kind   (segment_kind),
        .slot_index     (slot_index),
        .entry_high     (entry_high),
        .entry_low      (entry_low),
        .took_free_slot (took_free_slot)
    );

endmodule

// ===== sim/tb_tlb_refill_segment_round_robin.sv =====
module tb_tlb_refill_segment_round_robin;

    timeunit 1ns;
    timeprecision 1ps;

    import tlbr_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          SLOTS         = TLB_ENTRIES_DEF;
    localparam int          PAGE_BYTES    = 1 << PAGE_OFFSET_BITS_DEF;
    localparam logic [63:0] STACK_SPAN    = 64'(STACK_PAGES_DEF) << PAGE_OFFSET_BITS_DEF;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 8;
    localparam int          QUIET_LIMIT   = 1000;

    // indexes the block has no register behind
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 3'd7;

    typedef enum logic [1:0] {
        OP_REFILL,
        OP_WRITE,
        OP_PAUSE
    } op_kind_t;

    typedef enum int {
        GAPS_SPREAD,
        GAPS_NONE,
        GAPS_RARE
    } gap_mode_t;

    typedef struct {
        op_kind_t               kind;
        logic [ADDR_W-1:0]      fault;
        logic [ADDR_W-1:0]      frame;
        logic [CFG_INDEX_W-1:0] index;
        logic [ADDR_W-1:0]      data;
        int                     gap;
    } pending_op_t;

    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]     high;
        logic [ADDR_W-1:0]     low;
        logic                  took_free;
    } refill_t;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   start          = 1'b0;
    logic [ADDR_W-1:0]      fault_address  = '0;
    logic [ADDR_W-1:0]      frame_address  = '0;
    logic                   cfg_valid      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [ADDR_W-1:0]      cfg_data       = '0;
    logic                   busy;
    logic                   done;
    logic [1:0]             segment_kind;
    logic [SLOT_OUT_W-1:0]  slot_index;
    logic [ADDR_W-1:0]      entry_high;
    logic [ADDR_W-1:0]      entry_low;
    logic                   took_free_slot;
    logic                   cfg_ready;

    pending_op_t pending_ops[$];
    refill_t     refills_due[$];

    // driver state
    pending_op_t cur_op;
    logic        op_loaded  = 1'b0;
    logic        op_active  = 1'b0;
    int          wait_left  = 0;
    logic        item_taken = 1'b0;
    logic        cfg_taken  = 1'b0;

    // stimulus planning
    cfg_t        planned_bounds;
    gap_mode_t   gap_mode = GAPS_SPREAD;

    // shadow of the TLB
    cfg_t             model_bounds;
    logic [SLOTS-1:0] slot_valid_model;
    int               victim_ptr;

    int mismatches   = 0;
    int quiet_cycles = 0;

    tlb_refill_segment_round_robin dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .fault_address  (fault_address),
        .frame_address  (frame_address),
        .done           (done),
        .segment_kind   (segment_kind),
        .slot_index     (slot_index),
        .entry_high     (entry_high),
        .entry_low      (entry_low),
        .took_free_slot (took_free_slot),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic refill_t predict_refill(input logic [ADDR_W-1:0] fault,
                                               input logic [ADDR_W-1:0] frame);
        refill_t           r;
        logic [ADDR_W-1:0] page_tag;
        logic [63:0]       page;
        logic [63:0]       code_end;
        logic [63:0]       data_end;
        logic [63:0]       stack_lo;
        int                slot;
        page_tag    = fault & ~ADDR_W'(PAGE_BYTES - 1);
        page        = 64'(page_tag);
        code_end    = 64'(model_bounds.code_base)
                    + (64'(model_bounds.code_pages) << PAGE_OFFSET_BITS_DEF);
        data_end    = 64'(model_bounds.data_base)
                    + (64'(model_bounds.data_pages) << PAGE_OFFSET_BITS_DEF);
        // saturate the stack base at zero
        stack_lo    = (64'(model_bounds.stack_top) >= STACK_SPAN)
                    ? 64'(model_bounds.stack_top) - STACK_SPAN : 64'd0;
        r.kind      = KIND_FAULT;
        r.slot      = '0;
        r.high      = '0;
        r.low       = '0;
        r.took_free = 1'b0;
        if (page >= 64'(model_bounds.code_base) && page < code_end)
            r.kind = KIND_CODE;
        else if (page >= 64'(model_bounds.data_base) && page < data_end)
            r.kind = KIND_DATA;
        else if (page >= stack_lo && page < 64'(model_bounds.stack_top))
            r.kind = KIND_STACK;
        if (r.kind == KIND_FAULT)
            return r;
        r.high = page_tag;
        if (r.kind == KIND_CODE)
            r.low = (frame & ~ENTRY_DIRTY_BIT) | ENTRY_VALID_BIT;
        else
            r.low = frame | ENTRY_DIRTY_BIT | ENTRY_VALID_BIT;
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_valid_model[i])
                slot = i;
        r.took_free = (slot >= 0);
        if (slot < 0) begin
            slot       = victim_ptr;
            victim_ptr = (victim_ptr + 1) % SLOTS;
        end
        slot_valid_model[slot] = 1'b1;
        r.slot = slot[SLOT_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_refill(input logic [ADDR_W-1:0] fault, input logic [ADDR_W-1:0] frame);
        int gap;
        case (gap_mode)
            GAPS_NONE: gap = 0;
            GAPS_RARE: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
            default:   gap = $urandom_range(0, 8);
        endcase
        pending_ops.push_back('{kind: OP_REFILL, fault: fault, frame: frame,
                                index: '0, data: '0, gap: gap});
    endtask

    task automatic queue_write(input logic [CFG_INDEX_W-1:0] index, input logic [ADDR_W-1:0] data);
        pending_ops.push_back('{kind: OP_WRITE, fault: '0, frame: '0,
                                index: index, data: data, gap: 0});
    endtask

    task automatic queue_pause();
        pending_ops.push_back('{kind: OP_PAUSE, fault: '0, frame: '0,
                                index: '0, data: '0, gap: 0});
    endtask

    // page counts go out with junk above bit 19, which the block must drop
    task automatic queue_bounds(input cfg_t b);
        planned_bounds = b;
        queue_write(REG_CODE_BASE, b.code_base);
        queue_write(REG_CODE_PAGES, {12'($urandom_range(0, 4095)), b.code_pages});
        queue_write(REG_DATA_BASE, b.data_base);
        queue_write(REG_DATA_PAGES, {12'($urandom_range(0, 4095)), b.data_pages});
        queue_write(REG_STACK_TOP, b.stack_top);
        if ($urandom_range(0, 2) == 0)
            queue_write(CFG_INDEX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                        $urandom());
    endtask

    function automatic logic [ADDR_W-1:0] pick_bound();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_F000;
            2:       return 32'($urandom_range(1, 20)) << PAGE_OFFSET_BITS_DEF;
            3:       return $urandom_range(0, 32'hFFFF_F000);
            default: return $urandom() & 32'hFFFF_F000;
        endcase
    endfunction

    function automatic logic [PAGES_W-1:0] pick_pages();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return PAGES_W'($urandom_range(1, 4));
            default: return PAGES_W'($urandom_range(1, 300));
        endcase
    endfunction

    // land from a page below a region to a page above it
    function automatic logic [ADDR_W-1:0] pick_fault(input cfg_t b);
        logic [63:0] lo;
        int unsigned npages;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                lo     = 64'(b.code_base);
                npages = b.code_pages;
            end
            3, 4, 5: begin
                lo     = 64'(b.data_base);
                npages = b.data_pages;
            end
            6, 7: begin
                lo     = 64'(b.stack_top) - STACK_SPAN;
                npages = STACK_PAGES_DEF;
            end
            default: return $urandom();
        endcase
        return 32'(lo - 64'(PAGE_BYTES)
                   + 64'($urandom_range(0, npages + 1)) * 64'(PAGE_BYTES)
                   + 64'($urandom_range(0, PAGE_BYTES - 1)));
    endfunction

    always @(negedge clk) begin : drive_words
        logic start_next;
        logic cfg_valid_next;
        start_next     = start;
        cfg_valid_next = cfg_valid;
        if (rst_n) begin
            if (start && item_taken) begin
                start_next = 1'b0;
                op_active  = 1'b0;
            end
            if (cfg_valid && cfg_taken) begin
                cfg_valid_next = 1'b0;
                op_active      = 1'b0;
            end
            if (!op_active && !op_loaded && pending_ops.size() != 0) begin
                cur_op    = pending_ops.pop_front();
                op_loaded = 1'b1;
                wait_left = cur_op.gap;
            end
            if (op_loaded) begin
                // hold register writes and pauses until every refill has come back
                if (cur_op.kind != OP_REFILL && (refills_due.size() != 0 || busy))
                    wait_left = SETTLE_CYCLES;
                if (wait_left > 0)
                    wait_left--;
                else begin
                    op_loaded = 1'b0;
                    case (cur_op.kind)
                        OP_REFILL: begin
                            start_next     = 1'b1;
                            fault_address <= cur_op.fault;
                            frame_address <= cur_op.frame;
                            op_active      = 1'b1;
                        end
                        OP_WRITE: begin
                            cfg_valid_next = 1'b1;
                            cfg_index     <= cur_op.index;
                            cfg_data      <= cur_op.data;
                            op_active      = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
        start     <= start_next;
        cfg_valid <= cfg_valid_next;
    end

    always @(posedge clk or negedge rst_n) begin : watch_words
        refill_t want;
        if (!rst_n) begin
            item_taken      <= 1'b0;
            cfg_taken       <= 1'b0;
            model_bounds     = '{code_base: '0, code_pages: '0, data_base: '0,
                                 data_pages: '0, stack_top: STACK_TOP_RESET};
            slot_valid_model = '0;
            victim_ptr       = 0;
        end else begin
            item_taken <= start && !busy;
            cfg_taken  <= cfg_valid && cfg_ready;
            if (done) begin
                if (refills_due.size() == 0) begin
                    $display({"%0t: unexpected word: expected none, got kind %0d slot %0d ",
                              "high 0x%08h low 0x%08h free %0b"},
                             $time, segment_kind, slot_index, entry_high, entry_low,
                             took_free_slot);
                    mismatches++;
                end else begin
                    want = refills_due.pop_front();
                    check_field("segment_kind", want.kind, segment_kind);
                    check_field("slot_index", want.slot, slot_index);
                    check_field("entry_high", want.high, entry_high);
                    check_field("entry_low", want.low, entry_low);
                    check_field("took_free_slot", want.took_free, took_free_slot);
                end
            end
            if (start && !busy)
                refills_due.push_back(predict_refill(fault_address, frame_address));
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_CODE_BASE:  model_bounds.code_base  = cfg_data;
                    REG_CODE_PAGES: model_bounds.code_pages = cfg_data[PAGES_W-1:0];
                    REG_DATA_BASE:  model_bounds.data_base  = cfg_data;
                    REG_DATA_PAGES: model_bounds.data_pages = cfg_data[PAGES_W-1:0];
                    REG_STACK_TOP:  model_bounds.stack_top  = cfg_data;
                    default: ;
                endcase
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("tlb_refill_segment_round_robin regression: fail");
                    $finish;
                end
            end
        end
    end

    initial begin : run_regression
        cfg_t bounds;

        // default bounds: only the stack just below 2 GiB is mapped
        queue_refill(32'h0000_0000, 32'h0000_0000);
        queue_refill(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_refill(32'h7FFE_E000, 32'h0000_0400);
        queue_refill(32'h7FFE_DFFF, 32'h1234_5678);
        queue_refill(32'h8000_0000, 32'hFFFF_FFFF);
        queue_pause();

        // unaligned code base, data running past the top of memory, stack clipped at zero
        queue_bounds('{code_base: 32'h0040_0800, code_pages: 20'h00010,
                       data_base: 32'hF000_0000, data_pages: 20'hFFFFF,
                       stack_top: 32'h0000_5000});
        queue_write(REG_UNUSED_FIRST, 32'hFFFF_FFFF);
        queue_write(REG_UNUSED_LAST, 32'hFFFF_FFFF);
        queue_refill(32'h0040_0ABC, 32'hFFFF_FFFF);
        queue_refill(32'h0040_1000, 32'hFFFF_FFFF);
        queue_refill(32'h0040_FFFF, 32'h0000_0600);
        queue_refill(32'h0041_0FFF, 32'h0000_0000);
        queue_refill(32'h0041_1000, 32'h0000_0000);
        queue_refill(32'hFFFF_FFFF, 32'h0000_0000);
        queue_refill(32'hF000_0000, 32'h0000_0200);
        queue_refill(32'hEFFF_FFFF, 32'hFFFF_FFFF);
        queue_refill(32'h0000_0000, 32'h0000_0600);
        queue_refill(32'h0000_4FFF, 32'hAAAA_AAAA);
        queue_refill(32'h0000_5000, 32'h5555_5555);

        // code overlapping data, empty stack
        queue_bounds('{code_base: 32'hF000_0000, code_pages: 20'h00001,
                       data_base: 32'hF000_0000, data_pages: 20'hFFFFF,
                       stack_top: 32'h0000_0000});
        queue_refill(32'hF000_0123, 32'hFFFF_F9FF);
        queue_refill(32'hF000_1000, 32'h0000_0000);
        queue_refill(32'h0000_0000, 32'h0000_0000);

        // code and stack at the top of the address space, data empty
        queue_bounds('{code_base: 32'hFFFF_F000, code_pages: 20'hFFFFF,
                       data_base: 32'h0000_0000, data_pages: 20'h00000,
                       stack_top: 32'hFFFF_F000});
        queue_refill(32'hFFFF_FFFF, 32'h0000_0400);
        queue_refill(32'hFFFE_D123, 32'h0000_0000);
        queue_refill(32'hFFFE_CFFF, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0)
                bounds = '{code_base: '0, code_pages: '0, data_base: '0,
                           data_pages: '0, stack_top: '0};
            else if (phase == 1)
                bounds = '{code_base: 32'hFFFF_F000, code_pages: '1,
                           data_base: 32'hFFFF_F000, data_pages: '1,
                           stack_top: 32'hFFFF_F000};
            else
                bounds = '{code_base: pick_bound(), code_pages: pick_pages(),
                           data_base: pick_bound(), data_pages: pick_pages(),
                           stack_top: pick_bound()};
            queue_bounds(bounds);
            gap_mode = gap_mode_t'($urandom_range(0, 2));
            for (int n = 0; n < (phase == 0 ? 40 : 130); n++) begin
                if ($urandom_range(0, 49) == 0)
                    queue_pause();
                queue_refill(pick_fault(planned_bounds), $urandom());
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || op_loaded || op_active || refills_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tlb_refill_segment_round_robin regression: pass");
        else
            $display("tlb_refill_segment_round_robin regression: fail");
        $finish;
    end

endmodule
